>>> rtl/core/slm_pkg.sv
`default_nettype none
package slm_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;

  // Command codes carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MERGE  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_a;   // append to list A
    logic load_b;   // append to list B
    logic start;    // latch run length
    logic take;     // emit one element
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;    // both lists empty
    logic last;     // one element left in the run
    logic out_free; // output register can load this cycle
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/slm_datapath.sv
`default_nettype none
module slm_datapath #(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire slm_pkg::ctrl_t               ctrl,
  output slm_pkg::status_t                  status,
  input  wire logic [slm_pkg::DATA_W-1:0]   in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [slm_pkg::DATA_W-1:0]        out_value,
  output logic                              out_last
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int RW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [slm_pkg::DATA_W-1:0] mem_a [LIST_DEPTH];
  logic [slm_pkg::DATA_W-1:0] mem_b [LIST_DEPTH];

  logic [CW-1:0] count_a_r, count_a_nxt;
  logic [CW-1:0] count_b_r, count_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [slm_pkg::DATA_W-1:0] head_a_r, head_b_r;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r;
  logic [slm_pkg::DATA_W-1:0] out_value_r;

  logic a_avail, b_avail, take_a, finish, wr_a, wr_b;

  assign a_avail = (ia_r < count_a_r);
  assign b_avail = (ib_r < count_b_r);
  // ties go to B: A only when strictly smaller
  assign take_a  = a_avail && (!b_avail || ($signed(head_a_r) < $signed(head_b_r)));
  assign finish  = ctrl.take && status.last;
  assign wr_a    = ctrl.load_a && (count_a_r != DEPTH_C);
  assign wr_b    = ctrl.load_b && (count_b_r != DEPTH_C);

  assign status.empty    = (count_a_r == '0) && (count_b_r == '0);
  assign status.last     = (rem_r == RW'(1));
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (wr_a) begin
      count_a_nxt = count_a_r + CW'(1);
    end
    if (wr_b) begin
      count_b_nxt = count_b_r + CW'(1);
    end
    if (ctrl.start) begin
      rem_nxt = RW'(count_a_r) + RW'(count_b_r);
    end
    if (ctrl.take) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_r - RW'(1);
      if (take_a) begin
        ia_nxt = ia_r + CW'(1);
      end else begin
        ib_nxt = ib_r + CW'(1);
      end
    end
    if (finish) begin
      count_a_nxt = '0;
      count_b_nxt = '0;
      ia_nxt      = '0;
      ib_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // list memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a_r[AW-1:0]] <= in_value;
    end
    head_a_r <= mem_a[ia_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[count_b_r[AW-1:0]] <= in_value;
    end
    head_b_r <= mem_b[ib_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      out_value_r <= take_a ? head_a_r : head_b_r;
      out_last_r  <= status.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

>>> rtl/core/slm_ctrl.sv
`default_nettype none
module slm_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [slm_pkg::CMD_W-1:0]  in_cmd,
  input  wire slm_pkg::status_t           status,
  output slm_pkg::ctrl_t                  ctrl
);

  slm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      slm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // ready is high in idle, so valid alone marks a transaction
        if (in_valid) begin
          case (in_cmd)
            slm_pkg::CMD_LOAD_A: ctrl.load_a = 1'b1;
            slm_pkg::CMD_LOAD_B: ctrl.load_b = 1'b1;
            slm_pkg::CMD_MERGE: begin
              // merge of two empty lists emits nothing
              if (!status.empty) begin
                ctrl.start = 1'b1;
                state_nxt  = slm_pkg::ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      slm_pkg::ST_MERGE: begin
        if (status.out_free) begin
          ctrl.take = 1'b1;
          if (status.last) begin
            state_nxt = slm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = slm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/sorted_list_merge.sv
`default_nettype none
// Two-way merge of sorted lists. Each input transaction carries a command on
// in_tuser and a signed 32-bit value on in_tdata: load A and load B append the
// value to list A or B (up to LIST_DEPTH elements each; a load into a full
// list is dropped), merge emits every stored element, A and B interleaved in
// ascending order with ties going to B, one output transaction per element,
// tlast on the final one, then empties both lists. Merging two empty lists
// emits nothing; the unused command code is ignored. Loads are accepted back to
// back while idle. A merge keeps the input channel closed from its acceptance
// until its final element is taken, one element per cycle while out_tready
// stays high; that rate is set by the single registered read port of each
// list memory, which yields one new head per cycle. The output register lets
// loads for the next run be accepted while the final element still waits on
// out_tready. Lists that were not loaded in ascending order still emit each
// element exactly once, in compare-and-take order.
module sorted_list_merge #(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [slm_pkg::DATA_W-1:0]    in_tdata,   // [31:0] value
  input  wire logic [slm_pkg::CMD_W-1:0]     in_tuser,   // [1:0] cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [slm_pkg::DATA_W-1:0]         out_tdata,  // [31:0] out_value
  output logic                               out_tlast
);

  slm_pkg::ctrl_t   ctrl;
  slm_pkg::status_t status;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .status   (status),
    .ctrl     (ctrl)
  );

  slm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .status    (status),
    .in_value  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

  // Elements are only emitted while the input channel is closed
  a_take_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |-> !in_tready)
    else $error("element taken while input open");

  // A started run closes the input channel
  a_start_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> !in_tready)
    else $error("input open after merge start");

  // Taking the final element returns to idle and marks tlast
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.take && status.last) |=> (in_tready && out_tvalid && out_tlast))
    else $error("run did not end on last element");

  // A take always loads the output register
  a_take_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |=> out_tvalid)
    else $error("take without output transaction");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = slm_pkg::DATA_W;
  localparam int CMD_W       = slm_pkg::CMD_W;
  localparam int LIST_DEPTH  = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_ITEMS  = 330;
  localparam int HOLD_CYCLES = 400;   // long sink hold-off, fills the block
  localparam int DRAIN_WAIT  = 40;    // cycles allowed after the last result

  // cmd code the block ignores; not part of cmd_t
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Which side is allowed to idle.
  typedef enum int {
    PH_STEADY,       // no gaps, no stalls
    PH_SRC_GAPS,     // sender idles with 84% odds
    PH_SINK_STALLS,  // receiver stalls with 84% odds
    PH_BOTH          // both at 38% odds
  } idle_phase_t;

  // One input transaction. Rows with typed set carry up to two expected
  // results typed in by hand; all others are predicted.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    bit                typed;
    int                n_exp;
    logic [DATA_W-1:0] e0_val;
    bit                e0_last;
    logic [DATA_W-1:0] e1_val;
    bit                e1_last;
  } stim_row_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    bit                last;
  } merged_elem_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;    // [31:0] value
  logic [CMD_W-1:0]  in_tuser   = '0;    // [1:0] cmd
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;          // [31:0] out_value
  logic              out_tlast;

  // Shadow copy of both lists, updated on every accepted transaction.
  logic [DATA_W-1:0] shadow_a [LIST_DEPTH];
  logic [DATA_W-1:0] shadow_b [LIST_DEPTH];
  int                len_a = 0;
  int                len_b = 0;

  merged_elem_t      merged_q [$];   // merged elements still to come out
  stim_row_t         dir_tbl  [$];

  idle_phase_t       cur_phase  = PH_STEADY;
  bit                hold_req   = 1'b0;
  int                hold_left  = 0;
  int                err_cnt    = 0;
  int                cycle_cnt  = 0;
  int                rand_items = 0;

  sorted_list_merge #(.LIST_DEPTH(LIST_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // Runaway guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sorted_list_merge test failed");
      $finish;
    end
  end

  function automatic int src_idle_pct();
    case (cur_phase)
      PH_SRC_GAPS: return 84;
      PH_BOTH:     return 38;
      default:     return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case (cur_phase)
      PH_SINK_STALLS: return 84;
      PH_BOTH:        return 38;
      default:        return 0;
    endcase
  endfunction

  // Update the shadow lists for one command; on a merge, walk both lists
  // (A taken only when strictly smaller, so ties go to B) and optionally
  // queue the merged run.
  task automatic apply_to_lists(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                                input bit push_results);
    int ia;
    int ib;
    int total;
    bit take_a;
    merged_elem_t elem;
    ia = 0;
    ib = 0;
    case (cmd)
      slm_pkg::CMD_LOAD_A: begin
        if (len_a < LIST_DEPTH) begin
          shadow_a[len_a] = value;
          len_a++;
        end
      end
      slm_pkg::CMD_LOAD_B: begin
        if (len_b < LIST_DEPTH) begin
          shadow_b[len_b] = value;
          len_b++;
        end
      end
      slm_pkg::CMD_MERGE: begin
        total = len_a + len_b;
        for (int k = 0; k < total; k++) begin
          if (ia < len_a && ib < len_b)
            take_a = $signed(shadow_a[ia]) < $signed(shadow_b[ib]);
          else
            take_a = (ia < len_a);
          if (take_a) begin
            elem.value = shadow_a[ia];
            ia++;
          end else begin
            elem.value = shadow_b[ib];
            ib++;
          end
          elem.last = (k == total - 1);
          if (push_results) merged_q.push_back(elem);
        end
        len_a = 0;
        len_b = 0;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  function automatic stim_row_t mk_row(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v,
                                       bit t = 1'b0, int n = 0,
                                       logic [DATA_W-1:0] v0 = '0, bit l0 = 1'b0,
                                       logic [DATA_W-1:0] v1 = '0, bit l1 = 1'b0);
    stim_row_t r;
    r.cmd     = c;
    r.value   = v;
    r.typed   = t;
    r.n_exp   = n;
    r.e0_val  = v0;
    r.e0_last = l0;
    r.e1_val  = v1;
    r.e1_last = l1;
    return r;
  endfunction

  // Drive one transaction: optional gap, then hold tvalid until accepted.
  // Inputs change on the falling edge; tready is sampled on the rising edge.
  task automatic send_item(input stim_row_t r);
    int pct;
    merged_elem_t elem;
    pct = src_idle_pct();
    @(negedge clk);
    while ($urandom_range(0, 99) < pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= r.value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge
    apply_to_lists(r.cmd, r.value, !r.typed);
    if (r.typed) begin
      if (r.n_exp > 0) begin
        elem.value = r.e0_val;
        elem.last  = r.e0_last;
        merged_q.push_back(elem);
      end
      if (r.n_exp > 1) begin
        elem.value = r.e1_val;
        elem.last  = r.e1_last;
        merged_q.push_back(elem);
      end
    end
  endtask

  // 0 full range, 1 narrow window (many ties), 2 extremes, else any of these
  function automatic logic [DATA_W-1:0] pick_value(int vmode);
    int m;
    m = (vmode > 2) ? $urandom_range(0, 2) : vmode;
    case (m)
      0: return $urandom();
      1: return $urandom_range(0, 7) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // Load two lists (interleaved at random, optionally with unused codes mixed in), then merge.
  task automatic run_list_seq(input int na, input int nb, input bit sorted,
                              input int vmode, input bit noise);
    int va [$];
    int vb [$];
    int ia;
    int ib;
    for (int i = 0; i < na; i++) va.push_back(pick_value(vmode));
    for (int i = 0; i < nb; i++) vb.push_back(pick_value(vmode));
    if (sorted) begin
      va.sort();
      vb.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (noise && $urandom_range(0, 9) == 0)
        send_item(mk_row(CMD_UNUSED, $urandom()));
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        send_item(mk_row(slm_pkg::CMD_LOAD_A, va[ia]));
        ia++;
      end else begin
        send_item(mk_row(slm_pkg::CMD_LOAD_B, vb[ib]));
        ib++;
      end
    end
    send_item(mk_row(slm_pkg::CMD_MERGE, $urandom()));
    rand_items += na + nb + 1;
  endtask

  function automatic int list_len();
    // mostly short runs, now and then one close to or past full
    if ($urandom_range(0, 9) == 0) return $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 2);
    return $urandom_range(0, 6);
  endfunction

  // Receiver: random stalls per phase, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct());
    end
  end

  // Output check against the oldest expected element.
  always @(posedge clk) begin : out_check
    merged_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_q.size() == 0) begin
        $error("unexpected output transaction: out_value %h last %b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = merged_q.pop_front();
        if (out_tdata !== want.value) begin
          $error("out_value expected %h actual %h", want.value, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %b actual %b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int k;
    int cnt;

    // Directed rows. Typed expectations only where obvious.
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h0, 1, 0));         // empty after reset
    dir_tbl.push_back(mk_row(CMD_UNUSED, 32'hffff_ffff, 1, 0));         // ignored code
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'h7fff_ffff));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, 32'h8000_0000));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'hffff_ffff, 1, 2,
                             32'h8000_0000, 1'b0, 32'h7fff_ffff, 1'b1));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'h0000_0000));      // A only
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h0, 1, 1, 32'h0000_0000, 1'b1));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, 32'hffff_ffff));      // B only
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h5555_5555, 1, 1, 32'hffff_ffff, 1'b1));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'haaaa_aaaa, 1, 0)); // empty again
    // ties: equal heads go to B first
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, -32'sd3));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'd5));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, 32'd5));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'd7));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h0));
    // lists out of order
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'd9));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'd1));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, 32'd4));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_B, 32'h8000_0001));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h0));
    // unused code between a load and a merge leaves the list alone
    dir_tbl.push_back(mk_row(slm_pkg::CMD_LOAD_A, 32'd2));
    dir_tbl.push_back(mk_row(CMD_UNUSED, 32'h5555_5555, 1, 0));
    dir_tbl.push_back(mk_row(slm_pkg::CMD_MERGE, 32'h0, 1, 1, 32'd2, 1'b1));

    // synchronous reset
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) send_item(dir_tbl[i]);

    // Both lists past full while the sink holds off: the merge backs up
    // and the following loads stall on in_tready.
    hold_req = 1'b1;
    run_list_seq(LIST_DEPTH + 2, LIST_DEPTH + 2, 1'b1, 3, 1'b0);

    while (rand_items < RAND_ITEMS) begin
      cur_phase = idle_phase_t'((rand_items * 4 / RAND_ITEMS > 3) ? 3
                                : rand_items * 4 / RAND_ITEMS);
      k = $urandom_range(0, 99);
      if (k < 65) begin
        run_list_seq(list_len(), list_len(), 1'b1, $urandom_range(0, 3), k < 15);
      end else if (k < 80) begin
        run_list_seq(list_len(), list_len(), 1'b0, $urandom_range(0, 3), 1'b0);
      end else if (k < 95) begin
        // noise, then a merge of two empty lists
        cnt = $urandom_range(1, 3);
        for (int j = 0; j < cnt; j++) send_item(mk_row(CMD_UNUSED, $urandom()));
        send_item(mk_row(slm_pkg::CMD_MERGE, $urandom()));
        rand_items++;
      end else begin
        run_list_seq($urandom_range(LIST_DEPTH, LIST_DEPTH + 3),
                     $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 3), 1'b1,
                     $urandom_range(0, 3), 1'b0);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    while (merged_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("sorted_list_merge test passed");
    end else begin
      $display("sorted_list_merge test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
